[rtl/core/itnw_pkg.sv]
// package for the integer to number words block
// shared types and word codes; no dependencies
`default_nettype none

package itnw_pkg;

    localparam int unsigned VALUE_W    = 31;
    localparam int unsigned CODE_W     = 5;
    localparam int unsigned DIGITS     = 12;
    localparam int unsigned BCD_W      = DIGITS * 4;
    localparam int unsigned CONV_STEPS = VALUE_W;
    localparam int unsigned CNT_W      = 5;

    localparam logic [CODE_W-1:0] WORD_ZERO     = 5'd0;
    localparam logic [CODE_W-1:0] WORD_TEN      = 5'd10;
    localparam logic [CODE_W-1:0] WORD_TENS_OFS = 5'd18;
    localparam logic [CODE_W-1:0] WORD_HUNDRED  = 5'd28;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        STEP_HDIGIT,
        STEP_HWORD,
        STEP_TENS,
        STEP_ONES,
        STEP_SCALE
    } step_t;

endpackage

`default_nettype wire

[rtl/core/itnw_num_if.sv]
// handshake channel carrying one number word
// depends on itnw_pkg
`default_nettype none

interface itnw_num_if;
    logic                               valid;
    logic                               ready;
    logic [itnw_pkg::VALUE_W-1:0]       number_value;

    modport source (output valid, output number_value, input ready);
    modport sink   (input valid, input number_value, output ready);
endinterface

`default_nettype wire

[rtl/core/itnw_word_if.sv]
// handshake channel carrying one spelled word code
// depends on itnw_pkg
`default_nettype none

interface itnw_word_if;
    logic                               valid;
    logic                               ready;
    logic [itnw_pkg::CODE_W-1:0]        word_code;
    logic                               last_word;

    modport source (output valid, output word_code, output last_word, input ready);
    modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

`default_nettype wire

[rtl/core/integer_to_number_words_top.sv]
// integer to english number words: top level
// depends on itnw_pkg, itnw_num_if and itnw_word_if
//
//  channel    dir   payload                       word
//  number     in    number_value[30:0]            one integer to spell
//  spelling   out   word_code[4:0], last_word     one english word
//
// an integer goes through double-dabble conversion in one shared bcd
// adjust-and-shift unit, then 20 sequencer steps (4 groups x 5 slots),
// one word per step that yields a word; a zero input gives the single word zero
// output stalls hold the sequencer; number is ready only while idle
// reset clears the sequencer and the output valid
`default_nettype none

module integer_to_number_words_top (
    input  wire             clk,
    input  wire             rst_n,
    itnw_num_if.sink        number,
    itnw_word_if.source     spelling
);

    itnw_pkg::state_t                   state_reg, state_next;
    itnw_pkg::step_t                    step_reg, step_next;
    logic [1:0]                         group_reg, group_next;
    logic [itnw_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [itnw_pkg::VALUE_W-1:0]       bin_reg, bin_next;
    logic [itnw_pkg::BCD_W-1:0]         bcd_reg, bcd_next;
    logic                               zero_reg, zero_next;
    logic                               out_valid_reg, out_valid_next;
    logic [itnw_pkg::CODE_W-1:0]        out_code_reg, out_code_next;
    logic                               out_last_reg, out_last_next;

    logic [itnw_pkg::BCD_W-1:0]         bcd_adj;
    logic [11:0]                        grp;
    logic [3:0]                         hund, tens, ones;
    logic [3:0]                         groups_nz;
    logic [3:0]                         lower_mask;
    logic                               lower_nz;
    logic                               grp_nz;
    logic                               can_load;
    logic                               has_word;
    logic [itnw_pkg::CODE_W-1:0]        cur_code;
    logic                               cur_last;

    // shared adjust unit: add 3 to every digit of 5 or more
    always_comb
    begin
        for (int i = 0; i < itnw_pkg::DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        for (int g = 0; g < 4; g++)
            groups_nz[g] = |bcd_reg[g*12 +: 12];
    end

    assign grp        = bcd_reg[group_reg*12 +: 12];
    assign hund       = grp[11:8];
    assign tens       = grp[7:4];
    assign ones       = grp[3:0];
    assign grp_nz     = groups_nz[group_reg];
    assign lower_mask = (4'b0001 << group_reg) - 4'b0001;
    assign lower_nz   = |(groups_nz & lower_mask);
    assign can_load   = !out_valid_reg || spelling.ready;

    // word of the current slot
    always_comb
    begin
        has_word = 1'b0;
        cur_code = itnw_pkg::WORD_ZERO;
        cur_last = 1'b0;
        case (step_reg)
            itnw_pkg::STEP_HDIGIT:
            begin
                has_word = (hund != 4'd0);
                cur_code = {1'b0, hund};
            end
            itnw_pkg::STEP_HWORD:
            begin
                has_word = (hund != 4'd0);
                cur_code = itnw_pkg::WORD_HUNDRED;
                cur_last = (group_reg == 2'd0) && (tens == 4'd0) && (ones == 4'd0);
            end
            itnw_pkg::STEP_TENS:
            begin
                if (tens >= 4'd2)
                begin
                    has_word = 1'b1;
                    cur_code = itnw_pkg::WORD_TENS_OFS + {1'b0, tens};
                    cur_last = (group_reg == 2'd0) && (ones == 4'd0);
                end
                else if (tens == 4'd1)
                begin
                    has_word = 1'b1;
                    cur_code = itnw_pkg::WORD_TEN + {1'b0, ones};
                    cur_last = (group_reg == 2'd0);
                end
                else
                begin
                    has_word = (ones != 4'd0);
                    cur_code = {1'b0, ones};
                    cur_last = (group_reg == 2'd0);
                end
            end
            itnw_pkg::STEP_ONES:
            begin
                has_word = (tens >= 4'd2) && (ones != 4'd0);
                cur_code = {1'b0, ones};
                cur_last = (group_reg == 2'd0);
            end
            itnw_pkg::STEP_SCALE:
            begin
                has_word = (group_reg != 2'd0) && grp_nz;
                cur_code = itnw_pkg::WORD_HUNDRED + {3'b000, group_reg};
                cur_last = !lower_nz;
            end
            default:
            begin
                has_word = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        group_next     = group_reg;
        cnt_next       = cnt_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        zero_next      = zero_reg;
        out_code_next  = out_code_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !spelling.ready;
        number.ready   = 1'b0;

        case (state_reg)
            itnw_pkg::ST_IDLE:
            begin
                number.ready = 1'b1;
                if (number.valid)
                begin
                    bin_next   = number.number_value;
                    bcd_next   = '0;
                    zero_next  = (number.number_value == '0);
                    cnt_next   = '0;
                    state_next = itnw_pkg::ST_CONV;
                end
            end
            itnw_pkg::ST_CONV:
            begin
                bcd_next = {bcd_adj[itnw_pkg::BCD_W-2:0], bin_reg[itnw_pkg::VALUE_W-1]};
                bin_next = bin_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == itnw_pkg::CNT_W'(itnw_pkg::CONV_STEPS - 1))
                begin
                    state_next = itnw_pkg::ST_EMIT;
                    step_next  = itnw_pkg::STEP_HDIGIT;
                    group_next = 2'd3;
                end
            end
            itnw_pkg::ST_EMIT:
            begin
                if (zero_reg)
                begin
                    if (can_load)
                    begin
                        out_valid_next = 1'b1;
                        out_code_next  = itnw_pkg::WORD_ZERO;
                        out_last_next  = 1'b1;
                        state_next     = itnw_pkg::ST_IDLE;
                    end
                end
                else if (!has_word || can_load)
                begin
                    if (has_word)
                    begin
                        out_valid_next = 1'b1;
                        out_code_next  = cur_code;
                        out_last_next  = cur_last;
                    end
                    case (step_reg)
                        itnw_pkg::STEP_HDIGIT: step_next = itnw_pkg::STEP_HWORD;
                        itnw_pkg::STEP_HWORD:  step_next = itnw_pkg::STEP_TENS;
                        itnw_pkg::STEP_TENS:   step_next = itnw_pkg::STEP_ONES;
                        itnw_pkg::STEP_ONES:   step_next = itnw_pkg::STEP_SCALE;
                        default:
                        begin
                            step_next = itnw_pkg::STEP_HDIGIT;
                            if (group_reg == 2'd0)
                                state_next = itnw_pkg::ST_IDLE;
                            else
                                group_next = group_reg - 2'd1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = itnw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itnw_pkg::ST_IDLE;
            step_reg      <= itnw_pkg::STEP_HDIGIT;
            group_reg     <= 2'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            group_reg     <= group_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        zero_reg     <= zero_next;
        out_code_reg <= out_code_next;
        out_last_reg <= out_last_next;
    end

    assign spelling.valid     = out_valid_reg;
    assign spelling.word_code = out_code_reg;
    assign spelling.last_word = out_last_reg;

endmodule

`default_nettype wire

[test/testbench.sv]
// testbench for integer_to_number_words_top: spells integers and checks the word stream
// depends on itnw_pkg, itnw_num_if, itnw_word_if and the top level rtl
`timescale 1ns / 100ps

module testbench;

    localparam logic [itnw_pkg::CODE_W-1:0] WORD_THOUSAND = 5'd29;
    localparam longint unsigned             VALUE_MAX     = 64'd2147483647;

    typedef struct packed {
        logic [itnw_pkg::CODE_W-1:0] code;
        logic                        last;
    } spelled_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    itnw_num_if  number_ch ();
    itnw_word_if spelling_ch ();

    integer_to_number_words_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .number   (number_ch),
        .spelling (spelling_ch)
    );

    logic [itnw_pkg::VALUE_W-1:0] pending_numbers[$];
    spelled_word_t                expected_words[$];
    spelled_word_t                oldest_word;
    bit                           number_fired = 1'b0;
    int unsigned                  sender_idle_pct = 0;
    int unsigned                  receiver_stall_pct = 0;
    int unsigned                  hold_off_cycles = 0;
    int unsigned                  error_count = 0;

    int unsigned directed_values [24] = '{
        0, 1, 9, 10, 13, 19, 20, 21, 99, 100, 101, 115, 999, 1000,
        1000000, 1000000000, 1000001, 1001000, 1777777777, 2147483647,
        2000000000, 1010010010, 715827882, 1431655765
    };

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (error_count < 100)
            $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void push_word(input logic [itnw_pkg::CODE_W-1:0] code);
        spelled_word_t w;
        w.code = code;
        w.last = 1'b0;
        expected_words.push_back(w);
    endfunction

    // one three-digit group followed by its scale word; scale 0 is units
    function automatic void spell_group(input int unsigned group, input int unsigned scale);
        int unsigned hundreds;
        int unsigned rest;
        hundreds = group / 100;
        rest = group % 100;
        if (group == 0)
            return;
        if (hundreds != 0)
        begin
            push_word(itnw_pkg::CODE_W'(hundreds));
            push_word(itnw_pkg::WORD_HUNDRED);
        end
        if (rest >= 20)
        begin
            push_word(itnw_pkg::WORD_TENS_OFS + itnw_pkg::CODE_W'(rest / 10));
            if (rest % 10 != 0)
                push_word(itnw_pkg::CODE_W'(rest % 10));
        end
        else if (rest != 0)
            push_word(itnw_pkg::CODE_W'(rest));
        if (scale != 0)
            push_word(WORD_THOUSAND + itnw_pkg::CODE_W'(scale - 1));
    endfunction

    function automatic void spell_number(input logic [itnw_pkg::VALUE_W-1:0] value);
        int unsigned   v;
        spelled_word_t w;
        v = 32'(value);
        if (v == 0)
            push_word(itnw_pkg::WORD_ZERO);
        else
        begin
            spell_group((v / 1000000000) % 1000, 3);
            spell_group((v / 1000000) % 1000, 2);
            spell_group((v / 1000) % 1000, 1);
            spell_group(v % 1000, 0);
        end
        w = expected_words.pop_back();
        w.last = 1'b1;
        expected_words.push_back(w);
    endfunction

    // mix of full-range values, small values, values with empty groups and
    // values around powers of ten
    function automatic logic [itnw_pkg::VALUE_W-1:0] random_number();
        longint unsigned v;
        longint unsigned p;
        v = 0;
        case ($urandom_range(0, 3))
            0: v = 64'($urandom);
            1: v = 64'($urandom_range(0, 999));
            2:
            begin
                v = 64'($urandom_range(0, 2));
                repeat (3)
                    v = v * 1000 + 64'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 999));
                if (v > VALUE_MAX)
                    v = v - 1000000000;
            end
            default:
            begin
                p = 1;
                repeat ($urandom_range(0, 9))
                    p = p * 10;
                v = p + 64'($urandom_range(0, 2)) - 1;
            end
        endcase
        return itnw_pkg::VALUE_W'(v);
    endfunction

    task automatic wait_drained();
        while (pending_numbers.size() != 0 || expected_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int count, input int unsigned send_idle,
                             input int unsigned recv_stall);
        sender_idle_pct = send_idle;
        receiver_stall_pct = recv_stall;
        repeat (count)
            pending_numbers.push_back(random_number());
        wait_drained();
    endtask

    // number driver
    always @(negedge clk)
    begin
        if (number_fired)
            void'(pending_numbers.pop_front());
        if (!rst_n)
            number_ch.valid <= 1'b0;
        else if (number_ch.valid && !number_fired)
            ;
        else if (pending_numbers.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
        begin
            number_ch.valid <= 1'b1;
            number_ch.number_value <= pending_numbers[0];
        end
        else
            number_ch.valid <= 1'b0;
    end

    // spelling receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            spelling_ch.ready <= 1'b0;
        else if (hold_off_cycles != 0)
        begin
            spelling_ch.ready <= 1'b0;
            hold_off_cycles--;
        end
        else
            spelling_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        number_fired <= rst_n && number_ch.valid && number_ch.ready;
        if (rst_n && number_ch.valid && number_ch.ready)
            spell_number(number_ch.number_value);
        if (rst_n && spelling_ch.valid && spelling_ch.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch($sformatf("unexpected word code %0d last %0b",
                    spelling_ch.word_code, spelling_ch.last_word));
            else
            begin
                oldest_word = expected_words.pop_front();
                if (spelling_ch.word_code !== oldest_word.code)
                    report_mismatch($sformatf("word_code %0d, expected %0d",
                        spelling_ch.word_code, oldest_word.code));
                if (spelling_ch.last_word !== oldest_word.last)
                    report_mismatch($sformatf("last_word %0b, expected %0b (code %0d)",
                        spelling_ch.last_word, oldest_word.last, oldest_word.code));
            end
        end
    end

    initial
    begin
        number_ch.valid = 1'b0;
        number_ch.number_value = '0;
        spelling_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_values[i])
            pending_numbers.push_back(itnw_pkg::VALUE_W'(directed_values[i]));
        wait_drained();

        run_phase(110, 0, 0);
        run_phase(110, 78, 0);
        run_phase(110, 0, 78);
        run_phase(110, 30, 30);

        // long receiver hold-off while numbers keep coming
        hold_off_cycles = 400;
        run_phase(40, 0, 0);

        repeat (80)
            @(posedge clk);
        if (error_count == 0)
            $display("integer_to_number_words_top regression: pass");
        else
            $display("integer_to_number_words_top regression: fail");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("integer_to_number_words_top regression: fail");
        $finish;
    end

endmodule

[integer_to_number_words_top.f]
rtl/core/itnw_pkg.sv
rtl/core/itnw_num_if.sv
rtl/core/itnw_word_if.sv
rtl/core/integer_to_number_words_top.sv
test/testbench.sv
